>>> sv/tsrr_pkg.sv
// shared types, codes and helpers of the thread slot scheduler
package tsrr_pkg;

    localparam int THREAD_SLOTS = 4;
    localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_code;

    // slot state codes
    localparam t_code ST_FREE      = 2'd0;
    localparam t_code ST_RUNNING   = 2'd1;
    localparam t_code ST_RUNNABLE  = 2'd2;
    localparam t_code ST_SUSPENDED = 2'd3;

    // operation codes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_YIELD   = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_EXIT    = 3'd4;

    // status codes
    localparam logic [1:0] STS_DONE   = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_NOCHG  = 2'd2;
    localparam logic [1:0] STS_HALTED = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] target_slot;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] created_slot;
        logic [1:0] running_slot;
        logic       switched;
        logic       halted_flag;
    } t_out_word;

    typedef struct packed {
        logic  en;
        t_slot addr;
        t_code data;
    } t_wr_req;

    typedef struct packed {
        t_slot next;
        logic  match;
    } t_step_res;

    // state of a slot right after reset
    function automatic t_code slot_reset_code(t_slot idx);
        return (idx == '0) ? ST_RUNNING : ST_FREE;
    endfunction

    function automatic logic [1:0] slot_to_field(t_slot s);
        return 2'(s);
    endfunction

    function automatic logic tgt_in_range(logic [1:0] tgt);
        return int'(tgt) < THREAD_SLOTS;
    endfunction

    function automatic t_slot tgt_to_slot(logic [1:0] tgt);
        return t_slot'(tgt);
    endfunction

endpackage

>>> sv/tsrr_slot_table.sv
// slot state memory, one write and one registered read port, reset by valid bits
module tsrr_slot_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsrr_pkg::t_wr_req  i_wr,
    input  tsrr_pkg::t_slot    i_raddr,
    output tsrr_pkg::t_code    o_rdata
);

    tsrr_pkg::t_code                   r_mem [tsrr_pkg::THREAD_SLOTS];
    logic [tsrr_pkg::THREAD_SLOTS-1:0] r_vld;
    tsrr_pkg::t_code                   r_rd_data;
    tsrr_pkg::t_slot                   r_rd_addr;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_raddr];
        r_rd_addr <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    // never written entries read as their reset state
    assign o_rdata = r_rd_vld ? r_rd_data : tsrr_pkg::slot_reset_code(r_rd_addr);

endmodule

>>> sv/tsrr_step_unit.sv
// shared step unit: wrapping slot increment and state code compare
module tsrr_step_unit (
    input  tsrr_pkg::t_slot     i_idx,
    input  tsrr_pkg::t_code     i_code,
    input  tsrr_pkg::t_code     i_want,
    output tsrr_pkg::t_step_res o_res
);

    localparam tsrr_pkg::t_slot LAST = tsrr_pkg::t_slot'(tsrr_pkg::THREAD_SLOTS - 1);

    always_comb begin
        o_res.next  = (i_idx == LAST) ? '0 : i_idx + tsrr_pkg::t_slot'(1);
        o_res.match = (i_code == i_want);
    end

endmodule

>>> sv/thread_slot_round_robin_scheduler_top.sv
// top level of the round robin thread slot scheduler with suspend and resume
//
// Keeps the state of THREAD_SLOTS thread slots (free, running, runnable,
// suspended) in a small memory and the current slot in a register. Each input
// word is one operation; each gives exactly one output word. The block takes
// one operation at a time: o_in_ready is high only while the sequencer is idle,
// even if the previous output word still waits in the output register. Slots
// are visited one per cycle through the single read port of the slot table. A
// create or a reschedule passes from acceptance through the scan state, where
// each slot is checked once its registered read data returns, to the response
// state; suspend or resume of another slot passes through the target check
// state, and a halted block or an unknown code goes straight to the response
// state. Rescheduling searches from the slot after the current one, wrapping,
// and ends at the current slot itself. With nothing runnable the block halts
// for good and answers every later operation with status halted. The slot
// table comes out of reset through per-entry valid bits, so no clearing pass is
// needed and the block is ready as soon as reset is released.
module thread_slot_round_robin_scheduler_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tsrr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsrr_pkg::t_out_word o_out_word
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_TGT_CHK = 4'b0100,
        S_RESP    = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    tsrr_pkg::t_slot     r_cur, n_cur;          // current slot
    logic                r_halted, n_halted;
    tsrr_pkg::t_slot     r_ptr, n_ptr;          // next slot to read
    tsrr_pkg::t_cnt      r_left, n_left;        // slots not yet read
    logic                r_pend, n_pend;        // read data in flight
    tsrr_pkg::t_slot     r_pidx, n_pidx;        // slot of the read data
    tsrr_pkg::t_code     r_want, n_want;        // state searched for
    tsrr_pkg::t_code     r_code, n_code;        // state written on a hit
    logic                r_is_create, n_is_create;
    tsrr_pkg::t_out_word r_res, n_res;
    logic                r_out_valid, n_out_valid;
    tsrr_pkg::t_out_word r_out_word, n_out_word;

    tsrr_pkg::t_wr_req   wr;
    tsrr_pkg::t_slot     raddr;
    tsrr_pkg::t_code     rdata;
    tsrr_pkg::t_slot     step_idx;
    tsrr_pkg::t_step_res step;

    logic                in_acc;
    tsrr_pkg::t_slot     tslot;
    logic                tgt_ok;

    tsrr_slot_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // idle uses the unit for current plus one, the scan for the read pointer
    assign step_idx = (r_state == S_IDLE) ? r_cur : r_ptr;

    tsrr_step_unit u_step (
        .i_idx  (step_idx),
        .i_code (rdata),
        .i_want (r_want),
        .o_res  (step)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign tslot       = tsrr_pkg::tgt_to_slot(i_in_word.target_slot);
    assign tgt_ok      = tsrr_pkg::tgt_in_range(i_in_word.target_slot);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_halted    = r_halted;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_want      = r_want;
        n_code      = r_code;
        n_is_create = r_is_create;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        wr.en       = 1'b0;
        wr.addr     = r_pidx;
        wr.data     = r_code;
        raddr       = r_ptr;

        // output register drains independently of the sequencer
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res.status       = tsrr_pkg::STS_NOCHG;
                    n_res.created_slot = 2'd0;
                    n_res.running_slot = tsrr_pkg::slot_to_field(r_cur);
                    n_res.switched     = 1'b0;
                    n_res.halted_flag  = r_halted;
                    n_state            = S_RESP;
                    // reschedule start, overridden where not needed
                    n_ptr       = step.next;
                    n_left      = tsrr_pkg::t_cnt'(tsrr_pkg::THREAD_SLOTS);
                    n_pend      = 1'b0;
                    n_want      = tsrr_pkg::ST_RUNNABLE;
                    n_code      = tsrr_pkg::ST_RUNNING;
                    n_is_create = 1'b0;
                    wr.addr     = r_cur;
                    if (r_halted) begin
                        n_res.status = tsrr_pkg::STS_HALTED;
                    end else begin
                        unique case (i_in_word.operation)
                            tsrr_pkg::OP_CREATE: begin
                                n_ptr       = '0;
                                n_want      = tsrr_pkg::ST_FREE;
                                n_code      = tsrr_pkg::ST_RUNNABLE;
                                n_is_create = 1'b1;
                                n_state     = S_SCAN;
                            end
                            tsrr_pkg::OP_YIELD: begin
                                wr.en   = 1'b1;
                                wr.data = tsrr_pkg::ST_RUNNABLE;
                                n_state = S_SCAN;
                            end
                            tsrr_pkg::OP_SUSPEND: begin
                                if (tgt_ok && tslot == r_cur) begin
                                    wr.en   = 1'b1;
                                    wr.data = tsrr_pkg::ST_SUSPENDED;
                                    n_state = S_SCAN;
                                end else if (tgt_ok) begin
                                    raddr   = tslot;
                                    n_pidx  = tslot;
                                    n_want  = tsrr_pkg::ST_RUNNABLE;
                                    n_code  = tsrr_pkg::ST_SUSPENDED;
                                    n_state = S_TGT_CHK;
                                end
                            end
                            tsrr_pkg::OP_RESUME: begin
                                if (tgt_ok) begin
                                    raddr   = tslot;
                                    n_pidx  = tslot;
                                    n_want  = tsrr_pkg::ST_SUSPENDED;
                                    n_code  = tsrr_pkg::ST_RUNNABLE;
                                    n_state = S_TGT_CHK;
                                end
                            end
                            tsrr_pkg::OP_EXIT: begin
                                wr.en   = 1'b1;
                                wr.data = tsrr_pkg::ST_FREE;
                                n_state = S_SCAN;
                            end
                            default: begin
                                // unknown code, nothing changes
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && step.match) begin
                    wr.en        = 1'b1;
                    n_res.status = tsrr_pkg::STS_DONE;
                    if (r_is_create) begin
                        n_res.created_slot = tsrr_pkg::slot_to_field(r_pidx);
                    end else begin
                        n_cur              = r_pidx;
                        n_res.running_slot = tsrr_pkg::slot_to_field(r_pidx);
                        n_res.switched     = (r_pidx != r_cur);
                    end
                    n_state = S_RESP;
                end else if (r_pend && r_left == '0) begin
                    if (r_is_create) begin
                        n_res.status = tsrr_pkg::STS_FULL;
                    end else begin
                        // nothing runnable: halt for good
                        n_halted          = 1'b1;
                        n_res.status      = tsrr_pkg::STS_HALTED;
                        n_res.halted_flag = 1'b1;
                    end
                    n_state = S_RESP;
                end else begin
                    // read the next slot while checking the one before
                    n_pend = (r_left != '0);
                    if (r_left != '0) begin
                        n_pidx = r_ptr;
                        n_ptr  = step.next;
                        n_left = r_left - tsrr_pkg::t_cnt'(1);
                    end
                end
            end
            S_TGT_CHK: begin
                if (step.match) begin
                    wr.en        = 1'b1;
                    n_res.status = tsrr_pkg::STS_DONE;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_word  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_halted    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_halted    <= n_halted;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_pidx      <= n_pidx;
        r_want      <= n_want;
        r_code      <= n_code;
        r_is_create <= n_is_create;
        r_res       <= n_res;
        r_out_word  <= n_out_word;
    end

`ifndef SYNTHESIS
    // a halt is permanent
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag dropped");

    // a halted result always reports the halted status
    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.halted_flag) |->
            (o_out_word.status == tsrr_pkg::STS_HALTED))
        else $error("halted result without halted status");

    // a switch only comes with a successful reschedule
    a_switch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.switched) |->
            (o_out_word.status == tsrr_pkg::STS_DONE))
        else $error("switch reported without done status");

    // the slot table is never written while a result waits to be loaded
    a_no_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |-> !wr.en)
        else $error("slot table written in response state");
`endif

endmodule

>>> tb/thread_slot_round_robin_scheduler_top_test.sv
// self-checking testbench of the round robin thread slot scheduler
`timescale 1ns / 1ps

module thread_slot_round_robin_scheduler_top_test;

    // operation codes the block must ignore
    localparam logic [2:0] OP_UNK_LO = 3'd5;
    localparam logic [2:0] OP_UNK_HI = 3'd7;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * (tsrr_pkg::THREAD_SLOTS + 3);

    // shadow of the slot table, the current slot and the halt flag, plus the
    // words the block still owes us, oldest first
    class sched_checker;
        tsrr_pkg::t_code     slot_tab[tsrr_pkg::THREAD_SLOTS];
        tsrr_pkg::t_slot     cur;
        logic                halt_f;
        tsrr_pkg::t_out_word expected_words[$];
        int                  errors;

        function new();
            int i;
            for (i = 0; i < tsrr_pkg::THREAD_SLOTS; i++) begin
                slot_tab[i] = (i == 0) ? tsrr_pkg::ST_RUNNING : tsrr_pkg::ST_FREE;
            end
            cur    = '0;
            halt_f = 1'b0;
            errors = 0;
        endfunction

        // round robin search from the slot after the current one, current last
        function logic [1:0] pick_next(output logic moved);
            int i;
            int idx;
            for (i = 1; i <= tsrr_pkg::THREAD_SLOTS; i++) begin
                idx = (int'(cur) + i) % tsrr_pkg::THREAD_SLOTS;
                if (slot_tab[idx] == tsrr_pkg::ST_RUNNABLE) begin
                    slot_tab[idx] = tsrr_pkg::ST_RUNNING;
                    moved         = (tsrr_pkg::t_slot'(idx) != cur);
                    cur           = tsrr_pkg::t_slot'(idx);
                    return tsrr_pkg::STS_DONE;
                end
            end
            halt_f = 1'b1;
            moved  = 1'b0;
            return tsrr_pkg::STS_HALTED;
        endfunction

        function tsrr_pkg::t_out_word predict_op(tsrr_pkg::t_in_word w);
            tsrr_pkg::t_out_word r;
            logic                moved;
            int                  tgt;
            int                  i;
            r        = '0;
            r.status = tsrr_pkg::STS_NOCHG;
            moved    = 1'b0;
            tgt      = int'(w.target_slot);
            if (halt_f) begin
                r.status = tsrr_pkg::STS_HALTED;
            end else begin
                case (w.operation)
                    tsrr_pkg::OP_CREATE: begin
                        r.status = tsrr_pkg::STS_FULL;
                        for (i = 0; i < tsrr_pkg::THREAD_SLOTS; i++) begin
                            if (slot_tab[i] == tsrr_pkg::ST_FREE) begin
                                slot_tab[i]    = tsrr_pkg::ST_RUNNABLE;
                                r.created_slot = 2'(i);
                                r.status       = tsrr_pkg::STS_DONE;
                                break;
                            end
                        end
                    end
                    tsrr_pkg::OP_YIELD: begin
                        slot_tab[cur] = tsrr_pkg::ST_RUNNABLE;
                        r.status      = pick_next(moved);
                    end
                    tsrr_pkg::OP_SUSPEND: begin
                        if (tgt < tsrr_pkg::THREAD_SLOTS) begin
                            if (tsrr_pkg::t_slot'(tgt) == cur) begin
                                slot_tab[tgt] = tsrr_pkg::ST_SUSPENDED;
                                r.status      = pick_next(moved);
                            end else if (slot_tab[tgt] == tsrr_pkg::ST_RUNNABLE) begin
                                slot_tab[tgt] = tsrr_pkg::ST_SUSPENDED;
                                r.status      = tsrr_pkg::STS_DONE;
                            end
                        end
                    end
                    tsrr_pkg::OP_RESUME: begin
                        if (tgt < tsrr_pkg::THREAD_SLOTS &&
                            slot_tab[tgt] == tsrr_pkg::ST_SUSPENDED) begin
                            slot_tab[tgt] = tsrr_pkg::ST_RUNNABLE;
                            r.status      = tsrr_pkg::STS_DONE;
                        end
                    end
                    tsrr_pkg::OP_EXIT: begin
                        slot_tab[cur] = tsrr_pkg::ST_FREE;
                        r.status      = pick_next(moved);
                    end
                    default: begin
                    end
                endcase
            end
            r.running_slot = 2'(cur);
            r.switched     = moved;
            r.halted_flag  = halt_f;
            return r;
        endfunction

        // dry run: would this word bring the scheduler to a halt
        function bit would_halt(tsrr_pkg::t_in_word w);
            tsrr_pkg::t_code     saved_tab[tsrr_pkg::THREAD_SLOTS];
            tsrr_pkg::t_slot     saved_cur;
            logic                saved_halt;
            tsrr_pkg::t_out_word r;
            saved_tab  = slot_tab;
            saved_cur  = cur;
            saved_halt = halt_f;
            r          = predict_op(w);
            slot_tab   = saved_tab;
            cur        = saved_cur;
            halt_f     = saved_halt;
            return r.halted_flag && !saved_halt;
        endfunction

        function void note_op(tsrr_pkg::t_in_word w);
            expected_words.push_back(predict_op(w));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_word(tsrr_pkg::t_out_word got);
            tsrr_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, raw", int'(got), 0);
            end else begin
                want = expected_words.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.created_slot !== want.created_slot)
                    report_mismatch("created_slot", got.created_slot, want.created_slot);
                if (got.running_slot !== want.running_slot)
                    report_mismatch("running_slot", got.running_slot, want.running_slot);
                if (got.switched !== want.switched)
                    report_mismatch("switched", got.switched, want.switched);
                if (got.halted_flag !== want.halted_flag)
                    report_mismatch("halted_flag", got.halted_flag, want.halted_flag);
            end
        endtask
    endclass

    // all block inputs start at known values
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    tsrr_pkg::t_in_word  i_in_word   = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    tsrr_pkg::t_out_word o_out_word;

    sched_checker sb;

    // idle rates in percent, changed per phase
    int tx_idle_pct = 6;
    int rx_idle_pct = 49;

    // long receiver hold-off: main bumps the request count, receiver counts it down
    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    thread_slot_round_robin_scheduler_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitors on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_op(i_in_word);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_out_word);
        end
    end

    function automatic tsrr_pkg::t_in_word mk_word(logic [2:0] op, logic [1:0] tgt);
        tsrr_pkg::t_in_word w;
        w.operation   = op;
        w.target_slot = tgt;
        return w;
    endfunction

    // offer one word, after an optional gap, and hold it until accepted;
    // returns just after the following falling edge with valid still high
    task automatic send_word(input tsrr_pkg::t_in_word w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 8) gap++;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random operation that keeps the scheduler alive
    task automatic send_random();
        tsrr_pkg::t_in_word w;
        int                 pick;
        pick          = $urandom_range(99);
        w.target_slot = 2'($urandom_range(3));
        if (pick < 25) begin
            w.operation = tsrr_pkg::OP_CREATE;
        end else if (pick < 45) begin
            w.operation = tsrr_pkg::OP_YIELD;
        end else if (pick < 67) begin
            w.operation = tsrr_pkg::OP_SUSPEND;
            // aim at the running slot often so suspend reschedules
            if ($urandom_range(99) < 40) w.target_slot = 2'(sb.cur);
        end else if (pick < 87) begin
            w.operation = tsrr_pkg::OP_RESUME;
        end else if (pick < 96) begin
            w.operation = tsrr_pkg::OP_EXIT;
        end else begin
            w.operation = 3'($urandom_range(OP_UNK_HI, OP_UNK_LO));
        end
        // a halt is permanent, so save it for the end of the run
        if (sb.would_halt(w)) w.operation = tsrr_pkg::OP_CREATE;
        send_word(w);
    endtask

    // sender pause until the block owes nothing
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int n;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: no-change cases on free slots, yield with only itself runnable
        send_word(mk_word(tsrr_pkg::OP_RESUME, 2'd2));
        send_word(mk_word(tsrr_pkg::OP_SUSPEND, 2'd3));
        send_word(mk_word(tsrr_pkg::OP_YIELD, 2'd0));
        // fill the table, then create on a full table
        send_word(mk_word(tsrr_pkg::OP_CREATE, 2'd0));
        send_word(mk_word(tsrr_pkg::OP_CREATE, 2'd3));
        send_word(mk_word(tsrr_pkg::OP_CREATE, 2'd1));
        send_word(mk_word(tsrr_pkg::OP_CREATE, 2'd2));
        // suspend a runnable slot, suspend it again, resume it, resume a runnable one
        send_word(mk_word(tsrr_pkg::OP_SUSPEND, 2'd2));
        send_word(mk_word(tsrr_pkg::OP_SUSPEND, 2'd2));
        send_word(mk_word(tsrr_pkg::OP_RESUME, 2'd2));
        send_word(mk_word(tsrr_pkg::OP_RESUME, 2'd1));
        // yield to the next slot, suspend the running slot, exit the running slot
        send_word(mk_word(tsrr_pkg::OP_YIELD, 2'd3));
        send_word(mk_word(tsrr_pkg::OP_SUSPEND, 2'd1));
        send_word(mk_word(tsrr_pkg::OP_EXIT, 2'd0));
        // unknown codes
        send_word(mk_word(OP_UNK_LO, 2'd3));
        send_word(mk_word(OP_UNK_LO + 3'd1, 2'd0));
        send_word(mk_word(OP_UNK_HI, 2'd1));
        // suspend and resume slot zero, create into the freed slot
        send_word(mk_word(tsrr_pkg::OP_SUSPEND, 2'd0));
        send_word(mk_word(tsrr_pkg::OP_RESUME, 2'd0));
        send_word(mk_word(tsrr_pkg::OP_CREATE, 2'd0));
        send_word(mk_word(tsrr_pkg::OP_RESUME, 2'd1));
        wait_drained();

        // phase 1: sender mostly busy, receiver stalls half the time
        for (n = 0; n < 350; n++) begin
            if (n == 150) hold_req_cnt++;
            send_random();
        end
        wait_drained();

        // phase 2: the other way round
        tx_idle_pct = 49;
        rx_idle_pct = 6;
        for (n = 0; n < 350; n++) begin
            if (n == 100) hold_req_cnt++;
            send_random();
        end
        wait_drained();

        // phase 3: no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (n = 0; n < 330; n++) send_random();
        wait_drained();

        // exit until nothing is runnable, then check that the halt sticks
        while (!sb.halt_f) send_word(mk_word(tsrr_pkg::OP_EXIT, 2'($urandom_range(3))));
        for (n = 0; n < 8; n++) send_random();
        i_in_valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
